FILE: hdl/ile_pkg.sv
package ile_pkg;

   localparam int CAPACITY   = 64;
   localparam int WORD_WIDTH = 32;

   // Port field widths.
   localparam int CMD_W    = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // The find and read reduction is split into groups of cells.
   localparam int GROUP_SIZE = 8;
   localparam int GRP_IDX_W  = $clog2(GROUP_SIZE);
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_SET    = 3'd2,
      CMD_GET    = 3'd3,
      CMD_REMOVE = 3'd4,
      CMD_FIND   = 3'd5,
      CMD_CLEAR  = 3'd6,
      CMD_NOP    = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_NULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_WRITE,
      CELL_REMOVE
   } cell_mode_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_GATHER,
      FSM_REPORT
   } fsm_state_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      cell_mode_type         mode;
      logic                  capture;
      logic [POS_W-1:0]      pos;
      logic [CNT_W-1:0]      count;
      logic [WORD_WIDTH-1:0] word;
   } cell_ctrl_type;

endpackage

FILE: hdl/ile_req_if.sv
interface ile_req_if;
   import ile_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [POS_W-1:0]  position;
   logic [DATA_W-1:0] value;

   modport source (output valid, output command, output position, output value,
                   input ready);
   modport sink   (input valid, input command, input position, input value,
                   output ready);
endinterface

interface ile_rsp_if;
   import ile_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   data_out;
   logic                found;
   logic [IDX_W-1:0]    found_index;
   logic [CNT_W-1:0]    length;
   logic                empty_res;

   modport source (output valid, output status, output data_out, output found,
                   output found_index, output length, output empty_res,
                   input ready);
   modport sink   (input valid, input status, input data_out, input found,
                   input found_index, input length, input empty_res,
                   output ready);
endinterface

FILE: hdl/ile_cell.sv
module ile_cell (
   input  logic                           clock,
   input  logic [ile_pkg::IDX_W-1:0]      cell_index,
   input  ile_pkg::cell_ctrl_type         ctrl,
   input  logic [ile_pkg::WORD_WIDTH-1:0] left_word,
   input  logic [ile_pkg::WORD_WIDTH-1:0] right_word,
   output logic [ile_pkg::WORD_WIDTH-1:0] word,
   output logic                           match,
   output logic [ile_pkg::WORD_WIDTH-1:0] tap
);
   import ile_pkg::*;

   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [WORD_WIDTH-1:0] tap_ff, tap_in;
   logic                  match_ff, match_in;
   logic [POS_W-1:0]      my_pos;
   logic                  at_pos, above_pos;

   assign my_pos    = POS_W'(cell_index);
   assign at_pos    = (my_pos == ctrl.pos);
   assign above_pos = (my_pos > ctrl.pos);

   // Each cell either holds, loads the broadcast word, or takes its
   // neighbor's word when the list opens or closes a gap.
   always_comb begin
      word_in = word_ff;
      case (ctrl.mode)
         CELL_INSERT: begin
            if (above_pos) begin
               word_in = left_word;
            end else if (at_pos) begin
               word_in = ctrl.word;
            end
         end
         CELL_WRITE: begin
            if (at_pos) begin
               word_in = ctrl.word;
            end
         end
         CELL_REMOVE: begin
            if (at_pos || above_pos) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   assign tap_in   = at_pos ? word_ff : '0;
   assign match_in = (word_ff == ctrl.word) && (CNT_W'(cell_index) < ctrl.count);

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (ctrl.capture) begin
         tap_ff   <= tap_in;
         match_ff <= match_in;
      end
   end

   assign word  = word_ff;
   assign match = match_ff;
   assign tap   = tap_ff;

endmodule

FILE: hdl/ile_reduce.sv
module ile_reduce (
   input  logic                           clock,
   input  logic [ile_pkg::CAPACITY-1:0]   match_vec,
   input  logic [ile_pkg::WORD_WIDTH-1:0] tap_vec [ile_pkg::CAPACITY],
   output logic                           any_match,
   output logic [ile_pkg::IDX_W-1:0]      first_index,
   output logic [ile_pkg::WORD_WIDTH-1:0] tap_word
);
   import ile_pkg::*;

   logic                  grp_any_ff [NUM_GROUPS];
   logic                  grp_any_in [NUM_GROUPS];
   logic [GRP_IDX_W-1:0]  grp_low_ff [NUM_GROUPS];
   logic [GRP_IDX_W-1:0]  grp_low_in [NUM_GROUPS];
   logic [WORD_WIDTH-1:0] grp_tap_ff [NUM_GROUPS];
   logic [WORD_WIDTH-1:0] grp_tap_in [NUM_GROUPS];

   // First level: lowest matching cell and OR of taps within each group.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g] = 1'b0;
         grp_low_in[g] = '0;
         grp_tap_in[g] = '0;
         for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               if (match_vec[g * GROUP_SIZE + k]) begin
                  grp_any_in[g] = 1'b1;
                  grp_low_in[g] = GRP_IDX_W'(k);
               end
               grp_tap_in[g] = grp_tap_in[g] | tap_vec[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_ff[g] <= grp_any_in[g];
         grp_low_ff[g] <= grp_low_in[g];
         grp_tap_ff[g] <= grp_tap_in[g];
      end
   end

   // Second level across the group results.
   always_comb begin
      any_match   = 1'b0;
      first_index = '0;
      tap_word    = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            any_match   = 1'b1;
            first_index = IDX_W'(g * GROUP_SIZE + int'(grp_low_ff[g]));
         end
         tap_word = tap_word | grp_tap_ff[g];
      end
   end

endmodule

FILE: hdl/indexed_list_engine_core.sv
// Indexed list engine. The list lives in a chain of 64 cells, one 32-bit
// word per cell, with a fill count in the controller. Every command word
// yields exactly one result word carrying a status (ok, index out of range,
// list full, null value), the word read by get or removed by remove, the
// find result with the lowest matching index, and the length after the
// command with an empty flag. Insert and remove move the whole chain at
// once, each cell taking its left or right neighbor's word. A command goes
// from acceptance to a valid result in these steps: the word is latched,
// the cells shift and capture their compare and read taps, the first level
// of the two-level tree registers its group results, and the result
// register takes the first match and the read word. A new command word is
// accepted only once the previous result has been loaded, so the block does
// not take a new command while one is in flight; a result that has not been
// taken yet holds the tree and the next command waits behind it.
module indexed_list_engine_core (
   input logic  clock,
   input logic  reset,
   ile_req_if.sink   req_chan,
   ile_rsp_if.source rsp_chan
);
   import ile_pkg::*;

   fsm_state_type state_ff, state_in;

   cmd_type               cmd_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [WORD_WIDTH-1:0] value_ff;
   status_type            status_ff, status_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic req_ready;
   logic exec_en;
   logic rsp_load;

   cell_ctrl_type ctrl;
   cell_mode_type exec_mode;
   logic [POS_W-1:0] exec_pos;

   // Cell chain wiring.
   logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
   logic [WORD_WIDTH-1:0] cell_tap  [CAPACITY];
   logic [CAPACITY-1:0]   cell_match;

   logic                  any_match;
   logic [IDX_W-1:0]      first_index;
   logic [WORD_WIDTH-1:0] tap_word;

   // Result register.
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [DATA_W-1:0]   rsp_data_ff,  rsp_data_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]    rsp_length_ff;
   logic                rsp_empty_ff;

   logic req_accept;
   logic is_null;
   logic is_full;

   assign req_accept = req_chan.valid && req_ready;
   assign is_null    = (value_ff == '0);
   assign is_full    = (count_ff >= CNT_W'(CAPACITY));

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_chan.valid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_GATHER;
         end
         FSM_GATHER: begin
            state_in = FSM_REPORT;
         end
         FSM_REPORT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      exec_en   = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         FSM_IDLE:   req_ready = 1'b1;
         FSM_EXEC:   exec_en   = 1'b1;
         FSM_GATHER: ;
         FSM_REPORT: rsp_load  = !rsp_valid_ff || rsp_chan.ready;
         default:    ;
      endcase
   end

   // Command decode: the status follows the order null, position, fullness.
   // Append is an insert at the current length.
   always_comb begin
      status_in = STATUS_OK;
      count_in  = count_ff;
      exec_mode = CELL_HOLD;
      exec_pos  = pos_ff;
      unique case (cmd_ff)
         CMD_APPEND: begin
            exec_pos = POS_W'(count_ff);
            if (is_null) begin
               status_in = STATUS_NULL;
            end else if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               exec_mode = CELL_INSERT;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         CMD_INSERT: begin
            if (is_null) begin
               status_in = STATUS_NULL;
            end else if (pos_ff > POS_W'(count_ff)) begin
               status_in = STATUS_RANGE;
            end else if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               exec_mode = CELL_INSERT;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         CMD_SET: begin
            if (is_null) begin
               status_in = STATUS_NULL;
            end else if (pos_ff >= POS_W'(count_ff)) begin
               status_in = STATUS_RANGE;
            end else begin
               exec_mode = CELL_WRITE;
            end
         end
         CMD_GET: begin
            if (pos_ff >= POS_W'(count_ff)) begin
               status_in = STATUS_RANGE;
            end
         end
         CMD_REMOVE: begin
            if (pos_ff >= POS_W'(count_ff)) begin
               status_in = STATUS_RANGE;
            end else begin
               exec_mode = CELL_REMOVE;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         CMD_FIND: begin
            if (is_null) begin
               status_in = STATUS_NULL;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // The cells only move during the execute cycle, and they capture their
   // read taps and compare results from the words held before the move.
   always_comb begin
      ctrl.mode    = exec_en ? exec_mode : CELL_HOLD;
      ctrl.capture = exec_en;
      ctrl.pos     = exec_pos;
      ctrl.count   = count_ff;
      ctrl.word    = value_ff;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word;
      logic [WORD_WIDTH-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_left
         assign left_word = cell_word[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_right
         assign right_word = cell_word[i+1];
      end

      ile_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i]),
         .match      (cell_match[i]),
         .tap        (cell_tap[i])
      );
   end

   ile_reduce u_reduce (
      .clock       (clock),
      .match_vec   (cell_match),
      .tap_vec     (cell_tap),
      .any_match   (any_match),
      .first_index (first_index),
      .tap_word    (tap_word)
   );

   // Result fields are zero unless the command produced them.
   always_comb begin
      rsp_data_in  = '0;
      rsp_found_in = 1'b0;
      rsp_index_in = '0;
      if (status_ff == STATUS_OK) begin
         case (cmd_ff)
            CMD_GET, CMD_REMOVE: begin
               rsp_data_in = DATA_W'(tap_word);
            end
            CMD_FIND: begin
               rsp_found_in = any_match;
               rsp_index_in = any_match ? first_index : '0;
            end
            default: begin
               rsp_data_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_en) begin
            count_ff <= count_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= cmd_type'(req_chan.command);
         pos_ff   <= req_chan.position;
         value_ff <= WORD_WIDTH'(req_chan.value);
      end
      if (exec_en) begin
         status_ff <= status_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= rsp_data_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_length_ff <= count_ff;
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.data_out    = rsp_data_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.found_index = rsp_index_ff;
   assign rsp_chan.length      = rsp_length_ff;
   assign rsp_chan.empty_res   = rsp_empty_ff;

   // The fill count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list count above capacity");

   // An accepted command word always goes straight to the execute step.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == FSM_EXEC)
      else $error("accepted command did not execute");

   // A shift up of the chain grows the list by one entry.
   assert property (@(posedge clock) disable iff (reset)
      exec_en && exec_mode == CELL_INSERT |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the count");

   // A shift down of the chain shrinks the list by one entry.
   assert property (@(posedge clock) disable iff (reset)
      exec_en && exec_mode == CELL_REMOVE |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not shrink the count");

   // A loaded result always reflects the count left by its own command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_length_ff == count_ff && rsp_empty_ff == (count_ff == '0))
      else $error("result length out of step with the count");

endmodule
